// ===== rtl/opps_pkg.sv =====
// Shared types and constants for the page-addressed pixel plotter.
// Used by every module of oled_pixel_plot_shadow; depends on nothing.
package opps_pkg;

    localparam int PAGES_DEF   = 8;
    localparam int COLUMNS_DEF = 128;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CMD_PAGE_BASE     = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH_BASE = 8'h10;

    typedef struct packed {
        logic [3:0] page;
        logic [7:0] col;
        logic [7:0] mask;
        logic       draw;
    } plot_cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PAGE,
        ST_COL_LO,
        ST_COL_HI,
        ST_DATA
    } back_state_t;

endpackage

// ===== rtl/opps_front.sv =====
// Front end: accepts plot transactions, clamps row and column, maps to page and bit.
// Depends on opps_pkg; feeds opps_queue.
module opps_front #(
    parameter int PAGES   = opps_pkg::PAGES_DEF,
    parameter int COLUMNS = opps_pkg::COLUMNS_DEF
) (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,    // x_column[6:0], y_row[14:7], zero[15]
    input  logic                s_tuser,    // draw_mode[0]
    input  logic                clearing,
    output logic                push_valid,
    input  logic                push_ready,
    output opps_pkg::plot_cmd_t push_data
);

    localparam logic [7:0] ROW_LAST  = 8'(PAGES * 8 - 1);
    localparam logic [7:0] COL_LAST  = 8'(COLUMNS - 1);
    localparam logic [3:0] PAGE_LAST = 4'(PAGES - 1);

    logic [7:0] row_c;
    logic [7:0] col_ext;
    logic [7:0] col_c;

    always_comb begin
        row_c   = (s_tdata[14:7] > ROW_LAST) ? ROW_LAST : s_tdata[14:7];
        col_ext = {1'b0, s_tdata[6:0]};
        col_c   = (col_ext > COL_LAST) ? COL_LAST : col_ext;
    end

    always_comb begin
        push_data.page = PAGE_LAST - row_c[6:3];
        push_data.col  = col_c;
        push_data.mask = 8'h80 >> row_c[2:0];
        push_data.draw = s_tuser;
    end

    assign push_valid = s_tvalid && !clearing;
    assign s_tready   = push_ready && !clearing;

endmodule

// ===== rtl/opps_queue.sv =====
// Short queue between front end and back end of the pixel plotter.
// Depends on opps_pkg for the entry type and depth.
module opps_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  opps_pkg::plot_cmd_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output opps_pkg::plot_cmd_t pop_data
);

    localparam int DEPTH = opps_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    opps_pkg::plot_cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/opps_back.sv =====
// Back end: shadow frame memory, clearing pass, read-modify-write and byte sequencer.
// Depends on opps_pkg; drains opps_queue and drives the output register.
module opps_back #(
    parameter int PAGES   = opps_pkg::PAGES_DEF,
    parameter int COLUMNS = opps_pkg::COLUMNS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  opps_pkg::plot_cmd_t q_data,
    output logic                clearing,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // out_byte[7:0]
    output logic                m_tuser,    // is_command[0]
    output logic                m_tlast     // last_of_run
);

    localparam int STORE = PAGES * COLUMNS;
    localparam int IDX_W = $clog2(STORE);

    logic [7:0] mem [STORE];

    opps_pkg::back_state_t state_reg, state_next;
    opps_pkg::plot_cmd_t   cur_reg;
    logic [IDX_W-1:0]      cur_idx_reg;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [7:0]            rd_data_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg;
    logic                  out_cmd_reg;
    logic                  out_last_reg;

    logic             load, pop, we;
    logic [IDX_W-1:0] raddr, waddr;
    logic [IDX_W:0]   raddr_wide;
    logic [7:0]       wdata, new_data;
    logic [7:0]       beat_byte;
    logic             beat_cmd, beat_last;

    assign raddr_wide = (IDX_W + 1)'(q_data.page) * (IDX_W + 1)'(COLUMNS)
                      + (IDX_W + 1)'(q_data.col);
    assign raddr      = raddr_wide[IDX_W-1:0];
    assign new_data   = cur_reg.draw ? (rd_data_reg | cur_reg.mask) : 8'h00;
    assign load       = (!out_valid_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            opps_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(STORE - 1)) begin
                    state_next = opps_pkg::ST_IDLE;
                end
            end
            opps_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = opps_pkg::ST_PAGE;
                end
            end
            opps_pkg::ST_PAGE: begin
                if (load) begin
                    state_next = opps_pkg::ST_COL_LO;
                end
            end
            opps_pkg::ST_COL_LO: begin
                if (load) begin
                    state_next = opps_pkg::ST_COL_HI;
                end
            end
            opps_pkg::ST_COL_HI: begin
                if (load) begin
                    state_next = opps_pkg::ST_DATA;
                end
            end
            opps_pkg::ST_DATA: begin
                if (load) begin
                    state_next = q_valid ? opps_pkg::ST_PAGE : opps_pkg::ST_IDLE;
                end
            end
            default: state_next = opps_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        we        = 1'b0;
        waddr     = cur_idx_reg;
        wdata     = new_data;
        beat_byte = new_data;
        beat_cmd  = 1'b0;
        beat_last = 1'b0;
        clearing  = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            opps_pkg::ST_CLEAR: begin
                clearing = 1'b1;
                we       = 1'b1;
                waddr    = clr_cnt_reg;
                wdata    = 8'h00;
            end
            opps_pkg::ST_IDLE: begin
                pop = q_valid;
            end
            opps_pkg::ST_PAGE: begin
                beat_byte = opps_pkg::CMD_PAGE_BASE + {4'h0, cur_reg.page};
                beat_cmd  = 1'b1;
                out_valid_next = out_valid_next || load;
            end
            opps_pkg::ST_COL_LO: begin
                beat_byte = {4'h0, cur_reg.col[3:0]};
                beat_cmd  = 1'b1;
                out_valid_next = out_valid_next || load;
            end
            opps_pkg::ST_COL_HI: begin
                beat_byte = opps_pkg::CMD_COL_HIGH_BASE + {4'h0, cur_reg.col[7:4]};
                beat_cmd  = 1'b1;
                out_valid_next = out_valid_next || load;
            end
            opps_pkg::ST_DATA: begin
                beat_last = 1'b1;
                we        = load;
                pop       = load && q_valid;
                out_valid_next = out_valid_next || load;
            end
            default: clearing = 1'b1;
        endcase
    end

    assign q_ready = pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= opps_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg     <= q_data;
            cur_idx_reg <= raddr;
        end
        if (load && state_reg != opps_pkg::ST_CLEAR && state_reg != opps_pkg::ST_IDLE) begin
            out_byte_reg <= beat_byte;
            out_cmd_reg  <= beat_cmd;
            out_last_reg <= beat_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (pop) begin
            rd_data_reg <= (we && waddr == raddr) ? wdata : mem[raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_cmd_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !pop)
        else $error("queue drained during clearing pass");
    a_pop_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg == opps_pkg::ST_PAGE)
        else $error("popped item did not start a byte run");
    a_write_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && !clearing) |-> (state_reg == opps_pkg::ST_DATA && load))
        else $error("shadow write outside data beat");
    a_last_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> !m_tuser)
        else $error("run ended on a command byte");
`endif

endmodule

// ===== rtl/oled_pixel_plot_shadow.sv =====
// Top level of the page-addressed OLED pixel plotter with shadow frame store.
// Depends on opps_pkg, opps_front, opps_queue and opps_back.
//
// Each plot transaction (column, row, draw flag) produces four output
// transactions: page command, low column nibble, high column nibble, then the
// data byte with m_tlast set; m_tuser marks command bytes. Plots are issued at
// the pace of the single-byte output register draining its four-byte run;
// a two-entry queue lets new plots be taken while a run is still going out.
// After reset a clearing pass zeroes all PAGES*COLUMNS bytes of the shadow
// store (1024 by default), one byte per cycle, with s_tready low.
module oled_pixel_plot_shadow #(
    parameter int PAGES   = opps_pkg::PAGES_DEF,
    parameter int COLUMNS = opps_pkg::COLUMNS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // x_column[6:0], y_row[14:7], zero[15]
    input  logic        s_tuser,    // draw_mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte[7:0]
    output logic        m_tuser,    // is_command[0]
    output logic        m_tlast     // last_of_run
);

    opps_pkg::plot_cmd_t push_data, pop_data;
    logic push_valid, push_ready, pop_valid, pop_ready, clearing;

    opps_front #(.PAGES(PAGES), .COLUMNS(COLUMNS)) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    opps_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    opps_back #(.PAGES(PAGES), .COLUMNS(COLUMNS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_data   (pop_data),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
